@@ hw/rtl/dcdb_pkg.sv @@
// Shared types, codes and constants of the character display shadow buffer.
package dcdb_pkg;

	// Default store depth, in entries.
	localparam int BUFFER_DEPTH_DEFAULT = 256;

	// Action codes of a command transaction.
	localparam logic [2:0] ACT_WRITE  = 3'd0;
	localparam logic [2:0] ACT_CURSOR = 3'd1;
	localparam logic [2:0] ACT_START  = 3'd2;
	localparam logic [2:0] ACT_NEXT   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_OK    = 2'd0;
	localparam logic [1:0] KIND_RANGE = 2'd1;
	localparam logic [1:0] KIND_PRINT = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_DEVICES_ACROSS = 3'd0;
	localparam logic [2:0] CFG_DEVICES_DOWN   = 3'd1;
	localparam logic [2:0] CFG_DEVICE_COLUMNS = 3'd2;
	localparam logic [2:0] CFG_DEVICE_ROWS    = 3'd3;
	localparam logic [2:0] CFG_COLUMN_OFFSET  = 3'd4;
	localparam logic [2:0] CFG_ROW_OFFSET     = 3'd5;

	// Store entry layout: sent flag on top of a 7-bit code.
	localparam logic [7:0] SENT_BIT   = 8'h80;
	localparam logic [7:0] CODE_MASK  = 8'h7f;
	localparam logic [6:0] SPACE_CODE = 7'h20;

	// Command transaction payload.
	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  char_in;
		logic [15:0] cursor_column;
		logic [7:0]  cursor_line;
		logic        force_all;
	} cmd_t;

	// Result transaction payload.
	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] device_index;
		logic [7:0] phys_column;
		logic [5:0] phys_row;
		logic       move_cursor;
		logic [6:0] char_out;
	} res_t;

endpackage

@@ hw/rtl/dirty_char_display_buffer.sv @@
// Top level of the character display shadow buffer with per-entry sent tracking.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+--------------------------------
//  cmd     | in  | start & !busy              | dcdb_pkg::cmd_t
//  result  | out | done, one cycle, no stall  | dcdb_pkg::res_t
//  cfg     | in  | cfg_valid & cfg_ready      | cfg_index (3), cfg_data (8)
//
// Set cursor, start refresh, unused actions and refresh next with no scan
// running are handled in the idle state; the result follows on the next cycle.
// Write char runs row length, address multiply, range check and read, then
// compare and write back on the single memory port.
// Refresh next runs row length and multiply, a check and read per entry and a
// multiply per row entered, then the two-lane restoring divider (one bit a cycle) and emit.
// Clear and reset sweep the whole store with busy high.
// cfg_ready is always high; results cannot be held off by the receiver.
module dirty_char_display_buffer #(
	parameter int BUFFER_DEPTH = dcdb_pkg::BUFFER_DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dcdb_pkg::cmd_t  cmd,
	output logic            done,
	output dcdb_pkg::res_t  result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [7:0]      cfg_data
);

	localparam int AW     = $clog2(BUFFER_DEPTH);
	localparam int LEN_W  = 12;             // row length, up to 15 * 255
	localparam int ROW_W  = 11;             // scan row, up to 15 * 127
	localparam int PROD_W = LEN_W + ROW_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int DIV_W  = 13;             // physical column and row, offset plus scan position
	localparam int CNT_W  = $clog2(DIV_W);

	localparam logic [SUM_W-1:0] DEPTH_V   = SUM_W'(BUFFER_DEPTH);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_LEN,
		S_MUL,
		S_WCHK,
		S_WRD,
		S_CHK,
		S_RD,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [3:0] da_q, ddn_q;
	logic [7:0] dcol_q, coff_q, roff_q;
	logic [6:0] drow_q;

	// Architectural state
	logic [15:0]      cursor_col_q;
	logic [7:0]       cursor_row_q;
	logic [ROW_W-1:0] scan_row_q;
	logic [LEN_W-1:0] scan_col_q;
	logic             scan_active_q, scan_force_q;
	logic             exp_valid_q;
	logic [LEN_W-1:0] exp_col_q;
	logic [ROW_W-1:0] exp_row_q;

	// Working registers
	logic             op_write_q;
	logic [6:0]       char_q;
	logic [LEN_W-1:0] row_len_q;
	logic [ROW_W-1:0] rows_total_q;
	logic [PROD_W-1:0] prod_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    sweep_q;
	logic             sweep_reply_q;
	logic [7:0]       entry_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [DIV_W-1:0] quo_x_q, quo_y_q;
	logic [7:0]       rem_x_q, rem_y_q;
	logic             done_q;
	dcdb_pkg::res_t   result_q;

	// Memory port
	logic [7:0]    mem [BUFFER_DEPTH];
	logic [7:0]    rd_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;

	logic accept;
	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	// Address and bound checks
	logic [SUM_W-1:0] pos_w, pos_s;
	logic             wr_range, row_end, col_end;
	logic [ROW_W-1:0] mul_a;

	assign pos_w    = {1'b0, prod_q} + SUM_W'(cursor_col_q);
	assign pos_s    = {1'b0, prod_q} + SUM_W'(scan_col_q);
	assign wr_range = (pos_w >= DEPTH_V);
	assign row_end  = (scan_row_q >= rows_total_q) || ({1'b0, prod_q} >= DEPTH_V);
	assign col_end  = (scan_col_q >= row_len_q) || (pos_s >= DEPTH_V);
	assign mul_a    = op_write_q ? ROW_W'(cursor_row_q) : scan_row_q;

	// Physical position of the scanned entry
	logic [DIV_W-1:0] px, py;
	assign px = DIV_W'(coff_q) + DIV_W'(scan_col_q);
	assign py = DIV_W'(roff_q) + DIV_W'(scan_row_q);

	// One restoring step in each divider lane
	logic [8:0] tx, ty, dx, dy;
	logic       bx, by;
	logic [7:0] rem_x_n, rem_y_n;

	assign tx = {rem_x_q, quo_x_q[DIV_W-1]};
	assign ty = {rem_y_q, quo_y_q[DIV_W-1]};
	assign dx = {1'b0, dcol_q};
	assign dy = {2'b0, drow_q};
	assign bx = (tx >= dx);
	assign by = (ty >= dy);
	assign rem_x_n = bx ? 8'(tx - dx) : tx[7:0];
	assign rem_y_n = by ? 8'(ty - dy) : ty[7:0];

	// Emit values
	logic [5:0] dev_idx;
	logic       move_flag;
	assign dev_idx   = 6'({2'b0, da_q} * quo_y_q[5:0]) + quo_x_q[5:0];
	assign move_flag = !exp_valid_q || (exp_col_q != scan_col_q) || (exp_row_q != scan_row_q);

	// Drive the memory port from the current step
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = entry_q | dcdb_pkg::SENT_BIT;
		unique case (state_q)
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_addr  = sweep_q;
				mem_wdata = {1'b0, dcdb_pkg::SPACE_CODE};
			end
			S_WCHK: begin
				mem_re   = !wr_range;
				mem_addr = pos_w[AW-1:0];
			end
			S_WRD: begin
				mem_we    = ((rd_q & dcdb_pkg::CODE_MASK) != {1'b0, char_q});
				mem_wdata = {1'b0, char_q};
			end
			S_CHK: begin
				mem_re   = !row_end && !col_end;
				mem_addr = pos_s[AW-1:0];
			end
			S_EMIT: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Store: one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Take configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			da_q   <= 4'd2;
			ddn_q  <= 4'd1;
			dcol_q <= 8'd40;
			drow_q <= 7'd2;
			coff_q <= 8'd0;
			roff_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dcdb_pkg::CFG_DEVICES_ACROSS: da_q   <= cfg_data[3:0];
				dcdb_pkg::CFG_DEVICES_DOWN:   ddn_q  <= cfg_data[3:0];
				dcdb_pkg::CFG_DEVICE_COLUMNS: dcol_q <= cfg_data;
				dcdb_pkg::CFG_DEVICE_ROWS:    drow_q <= cfg_data[6:0];
				dcdb_pkg::CFG_COLUMN_OFFSET:  coff_q <= cfg_data;
				dcdb_pkg::CFG_ROW_OFFSET:     roff_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer: state, architectural registers and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			scan_row_q    <= '0;
			scan_col_q    <= '0;
			scan_active_q <= 1'b0;
			scan_force_q  <= 1'b0;
			exp_valid_q   <= 1'b0;
			exp_col_q     <= '0;
			exp_row_q     <= '0;
			op_write_q    <= 1'b0;
			char_q        <= '0;
			row_len_q     <= '0;
			rows_total_q  <= '0;
			prod_q        <= '0;
			addr_q        <= '0;
			sweep_q       <= '0;
			sweep_reply_q <= 1'b0;
			entry_q       <= '0;
			div_cnt_q     <= '0;
			quo_x_q       <= '0;
			quo_y_q       <= '0;
			rem_x_q       <= '0;
			rem_y_q       <= '0;
			done_q        <= 1'b0;
			result_q      <= '0;
		end else begin
			done_q   <= 1'b0;
			result_q <= '0;
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ADDR) begin
						state_q <= S_IDLE;
						if (sweep_reply_q) begin
							done_q        <= 1'b1;
							result_q.kind <= dcdb_pkg::KIND_OK;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						char_q <= cmd.char_in;
						unique case (cmd.action)
							dcdb_pkg::ACT_WRITE: begin
								op_write_q <= 1'b1;
								state_q    <= S_LEN;
							end
							dcdb_pkg::ACT_CURSOR: begin
								cursor_col_q <= cmd.cursor_column;
								cursor_row_q <= cmd.cursor_line;
								done_q       <= 1'b1;
							end
							dcdb_pkg::ACT_START: begin
								scan_active_q <= 1'b1;
								scan_force_q  <= cmd.force_all;
								scan_row_q    <= '0;
								scan_col_q    <= '0;
								exp_valid_q   <= 1'b0;
								exp_col_q     <= '0;
								exp_row_q     <= '0;
								done_q        <= 1'b1;
							end
							dcdb_pkg::ACT_NEXT: begin
								op_write_q <= 1'b0;
								if (scan_active_q) begin
									state_q <= S_LEN;
								end else begin
									done_q        <= 1'b1;
									result_q.kind <= dcdb_pkg::KIND_DONE;
								end
							end
							dcdb_pkg::ACT_CLEAR: begin
								cursor_col_q  <= '0;
								cursor_row_q  <= '0;
								sweep_q       <= '0;
								sweep_reply_q <= 1'b1;
								state_q       <= S_SWEEP;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_LEN: begin
					row_len_q    <= LEN_W'({8'b0, da_q} * {4'b0, dcol_q});
					rows_total_q <= ROW_W'({7'b0, ddn_q} * {4'b0, drow_q});
					state_q      <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(mul_a) * PROD_W'(row_len_q);
					state_q <= op_write_q ? S_WCHK : S_CHK;
				end
				S_WCHK: begin
					addr_q <= pos_w[AW-1:0];
					if (wr_range) begin
						done_q        <= 1'b1;
						result_q.kind <= dcdb_pkg::KIND_RANGE;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					cursor_col_q  <= cursor_col_q + 1'b1;
					done_q        <= 1'b1;
					result_q.kind <= dcdb_pkg::KIND_OK;
					state_q       <= S_IDLE;
				end
				S_CHK: begin
					addr_q <= pos_s[AW-1:0];
					if (row_end) begin
						scan_active_q <= 1'b0;
						done_q        <= 1'b1;
						result_q.kind <= dcdb_pkg::KIND_DONE;
						state_q       <= S_IDLE;
					end else if (col_end) begin
						scan_row_q <= scan_row_q + 1'b1;
						scan_col_q <= '0;
						state_q    <= S_MUL;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (scan_force_q || !rd_q[7]) begin
						entry_q   <= rd_q;
						quo_x_q   <= px;
						quo_y_q   <= py;
						rem_x_q   <= '0;
						rem_y_q   <= '0;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end else begin
						scan_col_q <= scan_col_q + 1'b1;
						state_q    <= S_CHK;
					end
				end
				S_DIV: begin
					rem_x_q   <= rem_x_n;
					rem_y_q   <= rem_y_n;
					quo_x_q   <= {quo_x_q[DIV_W-2:0], bx};
					quo_y_q   <= {quo_y_q[DIV_W-2:0], by};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					done_q                <= 1'b1;
					result_q.kind         <= dcdb_pkg::KIND_PRINT;
					result_q.device_index <= dev_idx;
					result_q.phys_column  <= rem_x_q;
					result_q.phys_row     <= rem_y_q[5:0];
					result_q.move_cursor  <= move_flag;
					result_q.char_out     <= entry_q[6:0];
					exp_row_q             <= scan_row_q;
					exp_col_q             <= scan_col_q + 1'b1;
					exp_valid_q           <= (rem_x_q != (dcol_q - 8'd1));
					scan_col_q            <= scan_col_q + 1'b1;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result only follows an accepted command or a busy step
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) || $past(busy)))
		else $error("result strobe without a command in flight");

	// A print result comes only out of the emit step
	a_print_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.kind == dcdb_pkg::KIND_PRINT) |-> $past(state_q == S_EMIT))
		else $error("print result outside the emit step");

	// The store is never written while waiting for a command
	a_idle_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != S_IDLE))
		else $error("store written while idle");

	// Non-print results carry an all-zero position and character
	a_zero_pay: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.kind != dcdb_pkg::KIND_PRINT) |->
		(result.device_index == 6'd0 && result.phys_column == 8'd0 &&
		 result.phys_row == 6'd0 && !result.move_cursor && result.char_out == 7'd0))
		else $error("non-print result with a payload");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the dirty-tracked character display shadow buffer.
module testbench;

	localparam int          DEPTH       = dcdb_pkg::BUFFER_DEPTH_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 20_000_000;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	dcdb_pkg::cmd_t  cmd = '0;
	logic            done;
	dcdb_pkg::res_t  result;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [2:0]      cfg_index = dcdb_pkg::CFG_DEVICES_ACROSS;
	logic [7:0]      cfg_data = '0;

	// Shadow of the display geometry registers
	int unsigned geo_across, geo_down, geo_columns, geo_rows, geo_col_off, geo_row_off;

	// Shadow of the character store, cursor and refresh scan
	logic [7:0]  shadow_store [DEPTH];
	logic [15:0] cur_col;
	logic [7:0]  cur_row;
	int unsigned scan_x, scan_y;
	logic        scan_on, scan_all;
	logic        follow_ok;
	int unsigned follow_x, follow_y;

	dcdb_pkg::res_t pending_results[$];
	dcdb_pkg::res_t oldest;
	logic [1:0]  last_kind;
	int          err_count = 0;
	int          n_items = 0;
	int          n_prints = 0;
	int          n_range = 0;
	int          n_settings = 0;
	int          calm_left = 0;
	int unsigned cycle_count = 0;

	dirty_char_display_buffer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result kind %0d with nothing pending", result.kind));
			end else begin
				oldest = pending_results.pop_front();
				if (result.kind !== oldest.kind)
					report_mismatch($sformatf("kind %h, want %h", result.kind, oldest.kind));
				if (result.device_index !== oldest.device_index)
					report_mismatch($sformatf("device_index %h, want %h",
						result.device_index, oldest.device_index));
				if (result.phys_column !== oldest.phys_column)
					report_mismatch($sformatf("phys_column %h, want %h",
						result.phys_column, oldest.phys_column));
				if (result.phys_row !== oldest.phys_row)
					report_mismatch($sformatf("phys_row %h, want %h",
						result.phys_row, oldest.phys_row));
				if (result.move_cursor !== oldest.move_cursor)
					report_mismatch($sformatf("move_cursor %h, want %h",
						result.move_cursor, oldest.move_cursor));
				if (result.char_out !== oldest.char_out)
					report_mismatch($sformatf("char_out %h, want %h",
						result.char_out, oldest.char_out));
			end
		end
	end

	function automatic void wipe_store();
		for (int i = 0; i < DEPTH; i++)
			shadow_store[i] = {1'b0, dcdb_pkg::SPACE_CODE};
		cur_col = '0;
		cur_row = '0;
	endfunction

	// Emit the next entry of the refresh that must go out, or finish the scan
	task automatic scan_next(output dcdb_pkg::res_t r);
		int unsigned row_len, rows_total, base, pos, px, py, dev;
		logic [7:0]  entry;
		r = '0;
		r.kind = dcdb_pkg::KIND_DONE;
		row_len = geo_across * geo_columns;
		rows_total = geo_down * geo_rows;
		while (scan_on) begin
			base = scan_y * row_len;
			if (scan_y >= rows_total || base >= DEPTH) begin
				scan_on = 1'b0;
				break;
			end
			if (scan_x >= row_len || base + scan_x >= DEPTH) begin
				scan_y++;
				scan_x = 0;
				continue;
			end
			pos = base + scan_x;
			entry = shadow_store[pos];
			if (scan_all || !entry[7]) begin
				px = geo_col_off + scan_x;
				py = geo_row_off + scan_y;
				dev = geo_across * (py / geo_rows) + px / geo_columns;
				r.kind = dcdb_pkg::KIND_PRINT;
				r.device_index = 6'(dev);
				r.phys_column = 8'(px % geo_columns);
				r.phys_row = 6'(py % geo_rows);
				r.move_cursor = !(follow_ok && follow_x == scan_x && follow_y == scan_y);
				r.char_out = entry[6:0];
				shadow_store[pos] = entry | dcdb_pkg::SENT_BIT;
				follow_y = scan_y;
				follow_x = scan_x + 1;
				follow_ok = ((px + 1) % geo_columns) != 0;
				scan_x++;
				return;
			end
			scan_x++;
		end
	endtask

	// Apply one command transaction to the shadow and work out its result
	task automatic shadow_step(input dcdb_pkg::cmd_t c, output dcdb_pkg::res_t r);
		int unsigned pos;
		r = '0;
		r.kind = dcdb_pkg::KIND_OK;
		case (c.action)
			dcdb_pkg::ACT_WRITE: begin
				pos = cur_row * geo_across * geo_columns + cur_col;
				if (pos >= DEPTH) begin
					r.kind = dcdb_pkg::KIND_RANGE;
				end else begin
					if (shadow_store[pos][6:0] != c.char_in)
						shadow_store[pos] = {1'b0, c.char_in};
					cur_col = cur_col + 16'd1;
				end
			end
			dcdb_pkg::ACT_CURSOR: begin
				cur_col = c.cursor_column;
				cur_row = c.cursor_line;
			end
			dcdb_pkg::ACT_START: begin
				scan_on = 1'b1;
				scan_all = c.force_all;
				scan_x = 0;
				scan_y = 0;
				follow_ok = 1'b0;
				follow_x = 0;
				follow_y = 0;
			end
			dcdb_pkg::ACT_NEXT: scan_next(r);
			dcdb_pkg::ACT_CLEAR: wipe_store();
			default: ;
		endcase
	endtask

	function automatic dcdb_pkg::cmd_t rand_cmd(input logic [2:0] act);
		dcdb_pkg::cmd_t c;
		c.action = act;
		c.char_in = 7'($urandom);
		c.cursor_column = 16'($urandom);
		c.cursor_line = 8'($urandom);
		c.force_all = ($urandom_range(0, 3) == 0);
		return c;
	endfunction

	function automatic bit coin(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Draw the sender gap, with occasional stretches of back-to-back commands
	function automatic int draw_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 18);
	endfunction

	// Send one command transaction and record its expected result
	task automatic issue(input dcdb_pkg::cmd_t c);
		int             gap;
		dcdb_pkg::res_t want;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		shadow_step(c, want);
		pending_results.push_back(want);
		last_kind = want.kind;
		n_items++;
		if (want.kind == dcdb_pkg::KIND_PRINT)
			n_prints++;
		if (want.kind == dcdb_pkg::KIND_RANGE)
			n_range++;
	endtask

	// Hold off until every result is in and the block is idle
	task automatic settle();
		if (start)
			start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 8'(value);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dcdb_pkg::CFG_DEVICES_ACROSS: geo_across = value & 32'hf;
			dcdb_pkg::CFG_DEVICES_DOWN:   geo_down = value & 32'hf;
			dcdb_pkg::CFG_DEVICE_COLUMNS: geo_columns = value & 32'hff;
			dcdb_pkg::CFG_DEVICE_ROWS:    geo_rows = value & 32'h7f;
			dcdb_pkg::CFG_COLUMN_OFFSET:  geo_col_off = value & 32'hff;
			dcdb_pkg::CFG_ROW_OFFSET:     geo_row_off = value & 32'hff;
			default: ;
		endcase
	endtask

	task automatic apply_geometry(input int unsigned across, down, columns, rows,
			col_off, row_off);
		settle();
		write_reg(dcdb_pkg::CFG_DEVICES_ACROSS, across);
		write_reg(dcdb_pkg::CFG_DEVICES_DOWN, down);
		write_reg(dcdb_pkg::CFG_DEVICE_COLUMNS, columns);
		write_reg(dcdb_pkg::CFG_DEVICE_ROWS, rows);
		write_reg(dcdb_pkg::CFG_COLUMN_OFFSET, col_off);
		write_reg(dcdb_pkg::CFG_ROW_OFFSET, row_off);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Mostly well-formed write bursts and refresh passes, with noise mixed in
	task automatic run_mixed(input int budget);
		int             goal, pick, cap, steps, row_len, rows_hit;
		int unsigned    pos;
		dcdb_pkg::cmd_t c;
		goal = n_items + budget;
		while (n_items < goal) begin
			pick = $urandom_range(0, 99);
			row_len = geo_across * geo_columns;
			if (pick < 40) begin
				// place the cursor on a row that reaches the store, then write a run of characters
				rows_hit = (row_len == 0) ? 4 : (DEPTH + row_len - 1) / row_len;
				c = rand_cmd(dcdb_pkg::ACT_CURSOR);
				c.cursor_line = 8'($urandom_range(0, rows_hit - 1));
				c.cursor_column = 16'($urandom_range(0,
					(row_len == 0 || row_len > DEPTH) ? DEPTH - 1 : row_len - 1));
				issue(c);
				repeat ($urandom_range(1, 12)) begin
					c = rand_cmd(dcdb_pkg::ACT_WRITE);
					pos = cur_row * geo_across * geo_columns + cur_col;
					if (pos < DEPTH && coin(35))
						c.char_in = shadow_store[pos][6:0];
					issue(c);
				end
			end else if (pick < 70) begin
				// start a refresh and step it, mostly until it finishes or the budget runs out
				issue(rand_cmd(dcdb_pkg::ACT_START));
				cap = coin(75) ? 400 : $urandom_range(1, 8);
				if (cap > goal - n_items + 8)
					cap = goal - n_items + 8;
				steps = 0;
				do begin
					if (coin(8))
						issue(rand_cmd(dcdb_pkg::ACT_WRITE));
					issue(rand_cmd(dcdb_pkg::ACT_NEXT));
					steps++;
				end while (last_kind == dcdb_pkg::KIND_PRINT && steps < cap);
			end else if (pick < 85) begin
				issue(rand_cmd(3'($urandom_range(0, 7))));
			end else if (pick < 89) begin
				issue(rand_cmd(dcdb_pkg::ACT_CLEAR));
			end else if (pick < 97) begin
				// cursor anywhere, usually past the store
				issue(rand_cmd(dcdb_pkg::ACT_CURSOR));
				issue(rand_cmd(dcdb_pkg::ACT_WRITE));
			end else begin
				settle();
			end
		end
	endtask

	task automatic test_directed();
		dcdb_pkg::cmd_t c;
		issue(rand_cmd(dcdb_pkg::ACT_NEXT));
		c = rand_cmd(dcdb_pkg::ACT_CURSOR);
		c.cursor_column = 16'd38;
		c.cursor_line = 8'd0;
		issue(c);
		c = rand_cmd(dcdb_pkg::ACT_WRITE);
		c.char_in = 7'h41;
		issue(c);
		c.char_in = 7'h7f;
		issue(c);
		c.char_in = 7'h00;
		issue(c);
		c.char_in = dcdb_pkg::SPACE_CODE;
		issue(c);
		c = rand_cmd(dcdb_pkg::ACT_CURSOR);
		c.cursor_column = 16'hffff;
		c.cursor_line = 8'hff;
		issue(c);
		issue(rand_cmd(dcdb_pkg::ACT_WRITE));
		c = rand_cmd(dcdb_pkg::ACT_CURSOR);
		c.cursor_column = 16'd79;
		c.cursor_line = 8'd1;
		issue(c);
		c = rand_cmd(dcdb_pkg::ACT_WRITE);
		c.char_in = 7'h55;
		issue(c);
		c = rand_cmd(dcdb_pkg::ACT_START);
		c.force_all = 1'b0;
		issue(c);
		repeat (4) issue(rand_cmd(dcdb_pkg::ACT_NEXT));
		// restart while a refresh is running
		c.force_all = 1'b1;
		issue(c);
		repeat (2) issue(rand_cmd(dcdb_pkg::ACT_NEXT));
		issue(rand_cmd(dcdb_pkg::ACT_CLEAR));
		issue(rand_cmd(3'd5));
		issue(rand_cmd(3'd6));
		issue(rand_cmd(3'd7));
		c = rand_cmd(dcdb_pkg::ACT_CURSOR);
		c.cursor_column = 16'd0;
		c.cursor_line = 8'd0;
		issue(c);
		c = rand_cmd(dcdb_pkg::ACT_WRITE);
		c.char_in = dcdb_pkg::SPACE_CODE;
		issue(c);
		issue(rand_cmd(dcdb_pkg::ACT_NEXT));
	endtask

	task automatic test_minimum_geometry();
		apply_geometry(1, 1, 1, 1, 0, 0);
		run_mixed(40);
	endtask

	task automatic test_maximum_geometry();
		apply_geometry(8, 8, 255, 64, 255, 255);
		run_mixed(90);
	endtask

	task automatic test_tiled_offsets();
		apply_geometry(3, 2, 5, 3, 7, 4);
		run_mixed(90);
	endtask

	task automatic test_empty_area();
		apply_geometry(0, 1, 40, 2, 0, 0);
		run_mixed(20);
		apply_geometry(2, 1, 40, 0, 3, 3);
		run_mixed(20);
		apply_geometry(2, 0, 0, 2, 0, 0);
		run_mixed(20);
	endtask

	task automatic test_random_geometry();
		repeat (5) begin
			apply_geometry($urandom_range(1, 8), $urandom_range(1, 8),
				coin(70) ? $urandom_range(1, 20) : $urandom_range(1, 255),
				coin(70) ? $urandom_range(1, 4) : $urandom_range(1, 64),
				$urandom_range(0, 255), $urandom_range(0, 255));
			run_mixed(55);
		end
	endtask

	initial begin
		geo_across = 2;
		geo_down = 1;
		geo_columns = 40;
		geo_rows = 2;
		geo_col_off = 0;
		geo_row_off = 0;
		wipe_store();
		scan_x = 0;
		scan_y = 0;
		scan_on = 1'b0;
		scan_all = 1'b0;
		follow_ok = 1'b0;
		follow_x = 0;
		follow_y = 0;
		last_kind = dcdb_pkg::KIND_OK;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// wait out the store sweep that follows reset
		while (busy) @(posedge clk);

		test_directed();
		run_mixed(60);
		test_minimum_geometry();
		test_maximum_geometry();
		test_tiled_offsets();
		test_empty_area();
		test_random_geometry();

		settle();
		repeat (300) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("ran %0d commands over %0d geometry settings plus reset values", n_items,
			n_settings);
		$display("%0d characters printed, %0d range errors, %0d mismatches", n_prints,
			n_range, err_count);
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/dcdb_pkg.sv
hw/rtl/dirty_char_display_buffer.sv
sim/testbench.sv
